// ===== hw/rtl/iol_pkg.sv =====
// Package for the indexed ordered list: sizes and command codes.
// No dependencies.
`timescale 1ns / 1ps
package iol_pkg;
  localparam int Capacity = 32;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int DataW = 64;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_GET    = 3'd2,
    CMD_SET    = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;
endpackage

// ===== hw/rtl/iol_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module iol_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hw/rtl/indexed_ordered_list_top.sv =====
// Indexed ordered list: 64-bit handles stored in one RAM by position.
// Depends on iol_pkg and iol_ram.
//
// One transaction at a time. Get, set and append touch a single slot and need
// no shift. Insert and remove move entries one slot at a time through the
// RAM's single read port, each move a read state and then a write state.
// Errors, clear and unknown commands go straight from decide to the response.
// The input reopens the cycle after the response is taken.
`timescale 1ns / 1ps
module indexed_ordered_list_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_index,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [63:0] out_data,
  output logic [5:0]  out_position,
  output logic [5:0]  out_entries_held
);
  import iol_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_READ, ST_SHIFT_RD, ST_SHIFT_WR, ST_FINISH, ST_RESP
  } state_t;

  state_t state_r;
  logic [2:0]        cmd_r;
  logic [5:0]        idx_r;
  logic [DataW-1:0]  val_r;
  logic [CountW-1:0] count_r;
  logic [CountW-1:0] ptr_r;
  logic              out_valid_r;
  logic              status_r;
  logic [DataW-1:0]  data_r;
  logic [5:0]        pos_r;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [DataW-1:0]  wr_data;
  logic [AddrW-1:0]  rd_addr;
  logic [DataW-1:0]  rd_data;

  iol_ram #(.Width(DataW), .Depth(Capacity)) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [CountW:0] idx_ext;
  logic in_range;
  logic ins_ok;
  assign idx_ext  = (CountW + 1)'(idx_r);
  assign in_range = idx_ext < {1'b0, count_r};
  assign ins_ok   = (count_r != CountW'(Capacity)) &&
                    ((cmd_r == CMD_APPEND) || (idx_ext <= {1'b0, count_r}));

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_data = data_r;
  assign out_position = pos_r;
  assign out_entries_held = 6'(count_r);

  // insert: shift from top down (read ptr-1, write ptr); remove: read ptr+1, write ptr
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AddrW'(ptr_r);
    wr_data = rd_data;
    rd_addr = AddrW'(idx_r);
    case (state_r)
      ST_SHIFT_RD: begin
        if (cmd_r == CMD_REMOVE) begin
          rd_addr = AddrW'(ptr_r + 1'b1);
        end else begin
          rd_addr = AddrW'(ptr_r - 1'b1);
        end
      end
      ST_SHIFT_WR: wr_en = 1'b1;
      ST_FINISH: begin
        if (cmd_r == CMD_SET || cmd_r == CMD_INSERT || cmd_r == CMD_APPEND) begin
          wr_en   = 1'b1;
          wr_addr = AddrW'(ptr_r);
          wr_data = val_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r <= in_command;
            idx_r <= in_index;
            val_r <= in_value;
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          status_r <= 1'b1;
          data_r   <= '0;
          pos_r    <= '0;
          state_r  <= ST_RESP;
          case (cmd_r)
            CMD_INSERT, CMD_APPEND: begin
              if (ins_ok) begin
                if (cmd_r == CMD_APPEND) begin
                  idx_r <= 6'(count_r);
                end
                ptr_r   <= count_r;
                state_r <= (cmd_r == CMD_APPEND || idx_ext == {1'b0, count_r}) ?
                           ST_FINISH : ST_SHIFT_RD;
              end
            end
            CMD_GET, CMD_SET, CMD_REMOVE: begin
              if (in_range) begin
                state_r <= ST_READ;
              end
            end
            CMD_CLEAR: begin
              status_r <= 1'b0;
              count_r  <= '0;
            end
            default: ;
          endcase
        end
        ST_READ: begin
          data_r   <= rd_data;
          status_r <= 1'b0;
          ptr_r    <= CountW'(idx_r);
          if (cmd_r == CMD_REMOVE) begin
            state_r <= (idx_ext + 1'b1 == {1'b0, count_r}) ? ST_FINISH : ST_SHIFT_RD;
          end else if (cmd_r == CMD_SET) begin
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_RESP;
          end
        end
        ST_SHIFT_RD: state_r <= ST_SHIFT_WR;
        ST_SHIFT_WR: begin
          if (cmd_r == CMD_REMOVE) begin
            ptr_r   <= ptr_r + 1'b1;
            state_r <= (ptr_r + 2'd2 == count_r) ? ST_FINISH : ST_SHIFT_RD;
          end else begin
            ptr_r   <= ptr_r - 1'b1;
            state_r <= (ptr_r - 1'b1 == CountW'(idx_r)) ? ST_FINISH : ST_SHIFT_RD;
          end
        end
        ST_FINISH: begin
          if (cmd_r == CMD_REMOVE) begin
            count_r <= count_r - 1'b1;
          end else if (cmd_r != CMD_SET) begin
            count_r  <= count_r + 1'b1;
            status_r <= 1'b0;
            pos_r    <= idx_r;
          end
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/iol_checker.sv =====
// Port-level checks for the indexed ordered list, bound to the top level.
// Depends on indexed_ordered_list_top.
`timescale 1ns / 1ps
module iol_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [63:0] out_data,
  input logic [5:0]  out_position,
  input logic [5:0]  out_entries_held
);
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_held <= 6'd32) else $error("count above capacity");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_data == 64'd0 && out_position == 6'd0))
    else $error("error result carries data");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
endmodule

bind indexed_ordered_list_top iol_checker u_iol_checker (.*);

// ===== verif/indexed_ordered_list_top_test.sv =====
// Self-checking testbench for indexed_ordered_list_top: directed and random
// bursty commands against a behavioral list predictor; uses iol_pkg, list RTL.
`timescale 1ns / 1ps
module indexed_ordered_list_top_test;
  import iol_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  index;
    logic [63:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic        status;
    logic [63:0] data;
    logic [5:0]  position;
    logic [5:0]  entries_held;
  } list_resp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [5:0]  in_index;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [63:0] out_data;
  logic [5:0]  out_position;
  logic [5:0]  out_entries_held;

  list_cmd_t   pending_cmds[$];
  list_resp_t  expected_resps[$];
  logic [63:0] model_slots[Capacity];
  int          model_count;
  int          mismatch_count;
  int          burst_left;
  int          gap_left;
  int          hold_off_left;
  int          stall_phase;
  bit          hold_off_done;

  indexed_ordered_list_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_data(out_data), .out_position(out_position),
    .out_entries_held(out_entries_held)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic list_resp_t apply_list_cmd(list_cmd_t c);
    list_resp_t r;
    int idx;
    r = '{status: 1'b1, data: 64'd0, position: 6'd0, entries_held: 6'd0};
    idx = c.index;
    case (c.command)
      CMD_INSERT, CMD_APPEND: begin
        if (c.command == CMD_APPEND) idx = model_count;
        if (idx <= model_count && model_count < Capacity) begin
          for (int i = model_count; i > idx; i--) model_slots[i] = model_slots[i - 1];
          model_slots[idx] = c.value;
          model_count++;
          r.status = 1'b0;
          r.position = idx[5:0];
        end
      end
      CMD_GET, CMD_SET, CMD_REMOVE: begin
        if (idx < model_count) begin
          r.status = 1'b0;
          r.data = model_slots[idx];
          if (c.command == CMD_SET) model_slots[idx] = c.value;
          if (c.command == CMD_REMOVE) begin
            for (int i = idx; i + 1 < model_count; i++) model_slots[i] = model_slots[i + 1];
            model_count--;
          end
        end
      end
      CMD_CLEAR: begin
        r.status = 1'b0;
        model_count = 0;
      end
      default: ;
    endcase
    r.entries_held = model_count[5:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
    mismatch_count++;
  endtask

  function automatic list_cmd_t make_cmd(logic [2:0] c, int idx, logic [63:0] v);
    list_cmd_t t;
    t.command = c;
    t.index = idx[5:0];
    t.value = v;
    return t;
  endfunction

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // driver: bursts with gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        void'(pending_cmds.pop_front());
        expected_resps.push_back(apply_list_cmd({in_command, in_index, in_value}));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_valid <= 1'b1;
        {in_command, in_index, in_value} <= pending_cmds[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
      stall_phase <= 0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall <= hold_off_left > 1;
    end else if (!hold_off_done && expected_resps.size() > 0) begin
      hold_off_done <= 1'b1;
      hold_off_left <= 300;
      out_stall <= 1'b1;
    end else begin
      stall_phase <= (stall_phase + 1) % 64;
      out_stall <= (stall_phase < 24) ? 1'b0 : ($urandom_range(0, 2) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    list_resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected", {63'd0, out_status}, 64'd0);
      end else begin
        want = expected_resps.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_data !== want.data) report_mismatch("data", out_data, want.data);
        if (out_position !== want.position)
          report_mismatch("position", 64'(out_position), 64'(want.position));
        if (out_entries_held !== want.entries_held)
          report_mismatch("entries_held", 64'(out_entries_held), 64'(want.entries_held));
      end
    end
  end

  initial begin
    int fill;
    int c;
    int bound;
    mismatch_count = 0;
    rst_n = 1'b0;
    // directed: empty-list errors, fill to capacity, overflow, edges
    pending_cmds.push_back(make_cmd(CMD_GET, 0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_REMOVE, 0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_SET, 0, 64'd1));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 1, 64'd5));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_GET, 1, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_SET, 0, 64'hAAAA_5555_AAAA_5555));
    pending_cmds.push_back(make_cmd(CMD_REMOVE, 0, 64'd0));
    pending_cmds.push_back(make_cmd(3'd6, 0, 64'd0));
    pending_cmds.push_back(make_cmd(3'd7, 63, 64'd0));
    for (int i = 0; i < Capacity; i++) pending_cmds.push_back(make_cmd(CMD_APPEND, 0, rand_value()));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 0, 64'd1));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 64'd1));
    pending_cmds.push_back(make_cmd(CMD_GET, 31, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_GET, 32, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_REMOVE, 63, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_REMOVE, 31, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 31, 64'h5555_AAAA_5555_AAAA));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 64'd0));
    // random: track fill so indexes mostly land in range
    fill = 0;
    for (int n = 0; n < 1050; n++) begin
      c = $urandom_range(0, 99);
      bound = ($urandom_range(0, 9) == 0) ? 63 : fill + 1;
      if (c < 1) pending_cmds.push_back(make_cmd(CMD_CLEAR, $urandom_range(0, 63), rand_value()));
      else if (c < 2) pending_cmds.push_back(make_cmd(3'($urandom_range(6, 7)),
                                                      $urandom_range(0, 63), rand_value()));
      else begin
        if (c < 30) pending_cmds.push_back(make_cmd(CMD_INSERT, $urandom_range(0, bound),
                                                    rand_value()));
        else if (c < 45) pending_cmds.push_back(make_cmd(CMD_APPEND, $urandom_range(0, 63),
                                                         rand_value()));
        else if (c < 60) pending_cmds.push_back(make_cmd(CMD_GET, $urandom_range(0, bound),
                                                         rand_value()));
        else if (c < 75) pending_cmds.push_back(make_cmd(CMD_SET, $urandom_range(0, bound),
                                                         rand_value()));
        else pending_cmds.push_back(make_cmd(CMD_REMOVE, $urandom_range(0, bound), rand_value()));
      end
      // rough fill tracking for index bounds
      case (pending_cmds[$].command)
        CMD_INSERT: if (pending_cmds[$].index <= fill && fill < Capacity) fill++;
        CMD_APPEND: if (fill < Capacity) fill++;
        CMD_REMOVE: if (pending_cmds[$].index < fill) fill--;
        CMD_CLEAR: fill = 0;
        default: ;
      endcase
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (expected_resps.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_resps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/iol_pkg.sv
hw/rtl/iol_ram.sv
hw/rtl/indexed_ordered_list_top.sv
hw/rtl/iol_checker.sv
verif/indexed_ordered_list_top_test.sv
